// ----- sv/hsvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_pkg: shared types and constants for the HSV to RGB converter
// Field widths, sector codes, fixed-point constants and the stage enable group.
// ----------------------------------------------------------------------------
package hsvc_pkg;

	localparam int HUE_W   = 9;
	localparam int PCT_W   = 7;
	localparam int CHAN_W  = 8;
	localparam int FRAC_W  = 6;
	localparam int BASE_W  = 13;
	localparam int NUM_W   = 20;
	localparam int SCALED_W = 24;
	localparam int ZDIV_W  = 18;
	localparam int RMUL_W  = 17;
	localparam int PROD_W  = ZDIV_W + RMUL_W;
	localparam int RSHIFT  = 26;
	localparam int QUOT_W  = PROD_W - RSHIFT;

	localparam logic [HUE_W-1:0]  HUE_LIMIT  = 9'd360;
	localparam logic [PCT_W-1:0]  PCT_LIMIT  = 7'd100;
	localparam logic [FRAC_W-1:0] SECTOR_DEG = 6'd60;
	localparam logic [BASE_W-1:0] FULL_BASE  = 13'd6000;
	localparam logic [RMUL_W-1:0] RECIP_MUL  = 17'd107374;
	localparam logic [ZDIV_W-1:0] DIV_BASE   = 18'd625;
	localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hFF;

	typedef enum logic [2:0] {
		SEC_0,
		SEC_1,
		SEC_2,
		SEC_3,
		SEC_4,
		SEC_5
	} sector_t;

	typedef logic [BASE_W-1:0] base_t;
	typedef logic [NUM_W-1:0]  num_t;

	typedef struct packed {
		logic s4;
		logic s5;
	} div_en_t;

endpackage

// ----- sv/hsv_to_rgb_convert_top.sv -----
`timescale 1ns / 1ps
// Throughput: one word per cycle while out_stall is low; each of the five stages holds one word.
// Backpressure: a stage advances when it is empty or the next stage advances.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_top: HSV to RGB converter
// Clamps hue, saturation and brightness, selects the sector terms and scales
// each channel to 8 bits in a five-stage pipeline.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [hsvc_pkg::HUE_W-1:0]   hue,
	input  logic [hsvc_pkg::PCT_W-1:0]   saturation,
	input  logic [hsvc_pkg::PCT_W-1:0]   brightness,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hsvc_pkg::CHAN_W-1:0]  red,
	output logic [hsvc_pkg::CHAN_W-1:0]  green,
	output logic [hsvc_pkg::CHAN_W-1:0]  blue
);
	import hsvc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	div_en_t div_en;

	logic [HUE_W-1:0]  hue_c;
	logic [PCT_W-1:0]  sat_c, bri_c;
	sector_t           sec_c;
	logic [HUE_W-1:0]  base_deg;

	sector_t           sec_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic [PCT_W-1:0]  sat_s1, bri_s1;

	base_t fs, gs, pv, qv, tv;
	base_t rb, gb, bb;
	base_t rb_s2, gb_s2, bb_s2;
	logic [PCT_W-1:0] bri_s2;

	num_t rnum_s3, gnum_s3, bnum_s3;

	// advance when empty or when the next stage advances
	assign en_s5 = ~vld_s5 | ~out_stall;
	assign en_s4 = ~vld_s4 | en_s5;
	assign en_s3 = ~vld_s3 | en_s4;
	assign en_s2 = ~vld_s2 | en_s3;
	assign en_s1 = ~vld_s1 | en_s2;
	assign in_stall  = ~en_s1;
	assign out_valid = vld_s5;
	assign div_en.s4 = en_s4;
	assign div_en.s5 = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: clamp, sector and fraction
	always_comb begin
		hue_c = (hue > HUE_LIMIT) ? HUE_LIMIT : hue;
		sat_c = (saturation > PCT_LIMIT) ? PCT_LIMIT : saturation;
		bri_c = (brightness > PCT_LIMIT) ? PCT_LIMIT : brightness;
		if (hue_c >= HUE_LIMIT) begin
			sec_c    = SEC_0;
			base_deg = HUE_LIMIT;
		end else if (hue_c >= 9'd300) begin
			sec_c    = SEC_5;
			base_deg = 9'd300;
		end else if (hue_c >= 9'd240) begin
			sec_c    = SEC_4;
			base_deg = 9'd240;
		end else if (hue_c >= 9'd180) begin
			sec_c    = SEC_3;
			base_deg = 9'd180;
		end else if (hue_c >= 9'd120) begin
			sec_c    = SEC_2;
			base_deg = 9'd120;
		end else if (hue_c >= 9'd60) begin
			sec_c    = SEC_1;
			base_deg = 9'd60;
		end else begin
			sec_c    = SEC_0;
			base_deg = 9'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sec_s1  <= sec_c;
			frac_s1 <= FRAC_W'(hue_c - base_deg);
			sat_s1  <= sat_c;
			bri_s1  <= bri_c;
		end
	end

	// stage 2: v, p, q, t terms over 6000 and sector selection
	assign fs = BASE_W'(frac_s1) * BASE_W'(sat_s1);
	assign gs = BASE_W'(SECTOR_DEG - frac_s1) * BASE_W'(sat_s1);
	assign pv = BASE_W'(PCT_LIMIT - sat_s1) * BASE_W'(SECTOR_DEG);
	assign qv = FULL_BASE - fs;
	assign tv = FULL_BASE - gs;

	always_comb begin
		case (sec_s1)
			SEC_0: begin
				rb = FULL_BASE; gb = tv; bb = pv;
			end
			SEC_1: begin
				rb = qv; gb = FULL_BASE; bb = pv;
			end
			SEC_2: begin
				rb = pv; gb = FULL_BASE; bb = tv;
			end
			SEC_3: begin
				rb = pv; gb = qv; bb = FULL_BASE;
			end
			SEC_4: begin
				rb = tv; gb = pv; bb = FULL_BASE;
			end
			default: begin
				rb = FULL_BASE; gb = pv; bb = qv;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			rb_s2  <= rb;
			gb_s2  <= gb;
			bb_s2  <= bb;
			bri_s2 <= bri_s1;
		end
	end

	// stage 3: scale by brightness
	always_ff @(posedge clk) begin
		if (en_s3) begin
			rnum_s3 <= NUM_W'(bri_s2) * NUM_W'(rb_s2);
			gnum_s3 <= NUM_W'(bri_s2) * NUM_W'(gb_s2);
			bnum_s3 <= NUM_W'(bri_s2) * NUM_W'(bb_s2);
		end
	end

	// stages 4 and 5: floor to 8 bits
	hsvc_chan_div u_div_red (
		.clk     (clk),
		.en      (div_en),
		.num_s3  (rnum_s3),
		.chan_s5 (red)
	);

	hsvc_chan_div u_div_green (
		.clk     (clk),
		.en      (div_en),
		.num_s3  (gnum_s3),
		.chan_s5 (green)
	);

	hsvc_chan_div u_div_blue (
		.clk     (clk),
		.en      (div_en),
		.num_s3  (bnum_s3),
		.chan_s5 (blue)
	);

	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5))
		else $error("input stalled while a stage is empty");

	a_drain_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !out_stall) |=> out_valid)
		else $error("word lost between last two stages");

endmodule

// ----- sv/hsvc_chan_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_chan_div: channel scaling stages
// Computes floor(num * 255 / 600000) over two pipeline stages by reciprocal
// multiplication with a single correction step.
// ----------------------------------------------------------------------------
module hsvc_chan_div (
	input  logic                        clk,
	input  hsvc_pkg::div_en_t           en,
	input  hsvc_pkg::num_t              num_s3,
	output logic [hsvc_pkg::CHAN_W-1:0] chan_s5
);
	import hsvc_pkg::*;

	logic [SCALED_W-1:0] scaled;
	logic [ZDIV_W-1:0]   zdiv;
	logic [PROD_W-1:0]   prod;
	logic [QUOT_W-1:0]   qest_s4;
	logic [ZDIV_W-1:0]   zdiv_s4;
	logic [ZDIV_W-1:0]   back;
	logic [ZDIV_W-1:0]   rem;
	logic [QUOT_W:0]     quot;

	// num * 17 / 40000 equals num * 255 / 600000; strip the 2^6 factor first
	assign scaled = {num_s3, 4'b0000} + SCALED_W'(num_s3);
	assign zdiv   = scaled[SCALED_W-1:SCALED_W-ZDIV_W];
	assign prod   = PROD_W'(zdiv) * PROD_W'(RECIP_MUL);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			qest_s4 <= prod[PROD_W-1:RSHIFT];
			zdiv_s4 <= zdiv;
		end
	end

	assign back = ZDIV_W'(qest_s4) * DIV_BASE;
	assign rem  = zdiv_s4 - back;
	assign quot = (QUOT_W + 1)'(qest_s4) + (QUOT_W + 1)'(rem >= DIV_BASE);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			chan_s5 <= (quot > (QUOT_W + 1)'(CHAN_MAX)) ? CHAN_MAX : quot[CHAN_W-1:0];
		end
	end

endmodule
